// File: design/weighted_tree_distance_lca_defines.svh
// ----------------------------------------------------------------------------
// weighted_tree_distance_lca_defines
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_TREE_DISTANCE_LCA_DEFINES_SVH
`define WEIGHTED_TREE_DISTANCE_LCA_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define WTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define WTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define WTD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wtd_pkg.sv
// ----------------------------------------------------------------------------
// wtd_pkg
// Types, constants and helpers for the weighted tree distance block.
// ----------------------------------------------------------------------------
package wtd_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 10;
  localparam int NODE_W      = 10;
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int DEPTH_W     = 10;
  localparam int DIST_W      = 40;
  localparam int EDGE_W      = 30;
  localparam int FUNC_W      = 2;
  localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ANC_DEPTH   = MAX_NODES * LIFT_LEVELS;
  localparam int ANC_AW      = $clog2(ANC_DEPTH);

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LIFT_LEVELS - 1);

  // Function codes of an input transaction
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_ADD   = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_QUERY = FUNC_W'(2);

  // Result status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_ABSENT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_INIT,
    S_ADD_SUM,
    S_ADD_RD,
    S_ADD_WR,
    S_Q_INIT,
    S_Q_RDB,
    S_Q_ORDER,
    S_Q_LIFT,
    S_Q_LIFT_WR,
    S_Q_MEET,
    S_Q_JRD,
    S_Q_JCMP,
    S_Q_PAR,
    S_Q_PAR_WR,
    S_Q_LCA_RD,
    S_Q_LCA_SUB,
    S_RESULT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Table requests from the sequencer
  typedef struct packed {
    logic                anc_we;
    logic [NODE_W-1:0]   anc_wnode;
    logic [LVL_W-1:0]    anc_wlvl;
    logic [NODE_W-1:0]   anc_wdata;
    logic [NODE_W-1:0]   anc_rx;
    logic [NODE_W-1:0]   anc_ry;
    logic [LVL_W-1:0]    anc_rlvl;
    logic                nd_we;
    logic [NODE_W-1:0]   nd_waddr;
    logic [DEPTH_W-1:0]  dep_wdata;
    logic [DIST_W-1:0]   dist_wdata;
    logic [NODE_W-1:0]   nd_raddr;
  } tbl_req_t;

  // Registered read data back to the sequencer
  typedef struct packed {
    logic [NODE_W-1:0]  anc_x;
    logic [NODE_W-1:0]  anc_y;
    logic [DEPTH_W-1:0] dep;
    logic [DIST_W-1:0]  node_dist;
  } tbl_rsp_t;

  // Flat ancestor-table address of one row entry
  function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                 input logic [LVL_W-1:0] lvl);
    return ANC_AW'(ANC_AW'(node) * ANC_AW'(LIFT_LEVELS)) + ANC_AW'(lvl);
  endfunction

endpackage

// File: design/wtd_in_if.sv
// ----------------------------------------------------------------------------
// wtd_in_if
// Input channel: one tree command per transaction.
// ----------------------------------------------------------------------------
interface wtd_in_if;
  logic                        valid;
  logic                        ready;
  logic [wtd_pkg::FUNC_W-1:0]  func;
  logic [wtd_pkg::NODE_W-1:0]  first_node;
  logic [wtd_pkg::NODE_W-1:0]  second_node;
  logic [wtd_pkg::EDGE_W-1:0]  edge_length;

  modport source (output valid, func, first_node, second_node, edge_length,
                  input ready);
  modport sink (input valid, func, first_node, second_node, edge_length,
                output ready);
endinterface

// File: design/wtd_out_if.sv
// ----------------------------------------------------------------------------
// wtd_out_if
// Result channel: one query answer per transaction.
// ----------------------------------------------------------------------------
interface wtd_out_if;
  logic                        valid;
  logic                        ready;
  logic [wtd_pkg::DIST_W-1:0]  path_length;
  logic                        status;

  modport source (output valid, path_length, status, input ready);
  modport sink (input valid, path_length, status, output ready);
endinterface

// File: design/wtd_alu.sv
// ----------------------------------------------------------------------------
// wtd_alu
// Shared 40-bit add/subtract unit for root distances and path lengths.
// ----------------------------------------------------------------------------
module wtd_alu (
  input  wtd_pkg::alu_op_t            op,
  input  logic [wtd_pkg::DIST_W-1:0]  op_a,
  input  logic [wtd_pkg::DIST_W-1:0]  op_b,
  output logic [wtd_pkg::DIST_W-1:0]  result
);

  // Wrap modulo 2^40
  always_comb begin
    unique case (op)
      wtd_pkg::ALU_ADD: result = op_a + op_b;
      wtd_pkg::ALU_SUB: result = op_a - op_b;
      default:          result = op_a;
    endcase
  end

endmodule

// File: design/wtd_tables.sv
// ----------------------------------------------------------------------------
// wtd_tables
// Ancestor, depth and root-distance memories with registered reads.
// ----------------------------------------------------------------------------
module wtd_tables (
  input  logic               clk,
  input  wtd_pkg::tbl_req_t  req,
  output wtd_pkg::tbl_rsp_t  rsp
);

  logic [wtd_pkg::NODE_W-1:0]  anc_mem  [wtd_pkg::ANC_DEPTH];
  logic [wtd_pkg::DEPTH_W-1:0] dep_mem  [wtd_pkg::MAX_NODES];
  logic [wtd_pkg::DIST_W-1:0]  dist_mem [wtd_pkg::MAX_NODES];

  logic [wtd_pkg::NODE_W-1:0]  ax_r;
  logic [wtd_pkg::NODE_W-1:0]  ay_r;
  logic [wtd_pkg::DEPTH_W-1:0] dep_r;
  logic [wtd_pkg::DIST_W-1:0]  dist_r;
  logic                        rx_root_r;
  logic                        ry_root_r;
  logic                        nd_root_r;

  // Ancestor table: one write port, two read ports
  always_ff @(posedge clk) begin
    if (req.anc_we) begin
      anc_mem[wtd_pkg::anc_addr(req.anc_wnode, req.anc_wlvl)] <= req.anc_wdata;
    end
    ax_r <= anc_mem[wtd_pkg::anc_addr(req.anc_rx, req.anc_rlvl)];
    ay_r <= anc_mem[wtd_pkg::anc_addr(req.anc_ry, req.anc_rlvl)];
  end

  // Depth and distance tables share one node address
  always_ff @(posedge clk) begin
    if (req.nd_we) begin
      dep_mem[req.nd_waddr]  <= req.dep_wdata;
      dist_mem[req.nd_waddr] <= req.dist_wdata;
    end
    dep_r  <= dep_mem[req.nd_raddr];
    dist_r <= dist_mem[req.nd_raddr];
  end

  // Track root reads; the root row is never stored
  always_ff @(posedge clk) begin
    rx_root_r <= (req.anc_rx == '0);
    ry_root_r <= (req.anc_ry == '0);
    nd_root_r <= (req.nd_raddr == '0);
  end

  // Root is its own ancestor at depth zero and distance zero
  always_comb begin
    rsp.anc_x     = rx_root_r ? '0 : ax_r;
    rsp.anc_y     = ry_root_r ? '0 : ay_r;
    rsp.dep       = nd_root_r ? '0 : dep_r;
    rsp.node_dist = nd_root_r ? '0 : dist_r;
  end

endmodule

// File: design/wtd_seq.sv
// ----------------------------------------------------------------------------
// wtd_seq
// Sequencer: node insertion, level-by-level LCA walk, result register.
// ----------------------------------------------------------------------------
module wtd_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wtd_pkg::FUNC_W-1:0]  in_func,
  input  logic [wtd_pkg::NODE_W-1:0]  in_first,
  input  logic [wtd_pkg::NODE_W-1:0]  in_second,
  input  logic [wtd_pkg::EDGE_W-1:0]  in_edge,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wtd_pkg::DIST_W-1:0]  out_len,
  output logic                        out_status,
  output wtd_pkg::tbl_req_t           req,
  input  wtd_pkg::tbl_rsp_t           rsp
);

  wtd_pkg::state_t state_r, state_nxt;
  logic [wtd_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [wtd_pkg::NODE_W-1:0]      x_r, x_nxt;
  logic [wtd_pkg::NODE_W-1:0]      y_r, y_nxt;
  logic [wtd_pkg::LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [wtd_pkg::LIFT_LEVELS-1:0] diff_r, diff_nxt;
  logic [wtd_pkg::DEPTH_W-1:0]     depa_r, depa_nxt;
  logic [wtd_pkg::DIST_W-1:0]      acc_r, acc_nxt;
  logic [wtd_pkg::EDGE_W-1:0]      weight_r, weight_nxt;
  logic                            err_r, err_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [wtd_pkg::DIST_W-1:0]      out_len_r, out_len_nxt;
  logic                            out_status_r, out_status_nxt;

  wtd_pkg::alu_op_t            alu_op;
  logic [wtd_pkg::DIST_W-1:0]  alu_a;
  logic [wtd_pkg::DIST_W-1:0]  alu_b;
  logic [wtd_pkg::DIST_W-1:0]  alu_y;
  logic [wtd_pkg::NODE_W-1:0]  new_node;
  logic [wtd_pkg::DEPTH_W-1:0] diff_full;
  logic                        in_acc;

  wtd_alu u_alu (
    .op     (alu_op),
    .op_a   (alu_a),
    .op_b   (alu_b),
    .result (alu_y)
  );

  assign new_node   = cnt_r[wtd_pkg::NODE_W-1:0];
  assign in_ready   = (state_r == wtd_pkg::S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_len    = out_len_r;
  assign out_status = out_status_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wtd_pkg::S_IDLE;
      cnt_r       <= wtd_pkg::CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    lvl_r        <= lvl_nxt;
    diff_r       <= diff_nxt;
    depa_r       <= depa_nxt;
    acc_r        <= acc_nxt;
    weight_r     <= weight_nxt;
    err_r        <= err_nxt;
    out_len_r    <= out_len_nxt;
    out_status_r <= out_status_nxt;
  end

  // Next state, table requests and ALU selection
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    lvl_nxt        = lvl_r;
    diff_nxt       = diff_r;
    depa_nxt       = depa_r;
    acc_nxt        = acc_r;
    weight_nxt     = weight_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_len_nxt    = out_len_r;
    out_status_nxt = out_status_r;
    diff_full      = '0;

    alu_op = wtd_pkg::ALU_ADD;
    alu_a  = acc_r;
    alu_b  = rsp.node_dist;

    req            = '0;
    req.anc_rx     = x_r;
    req.anc_ry     = y_r;
    req.anc_rlvl   = lvl_r;
    req.anc_wnode  = new_node;
    req.anc_wlvl   = lvl_r;
    req.anc_wdata  = rsp.anc_x;
    req.nd_waddr   = new_node;
    req.nd_raddr   = x_r;
    req.dep_wdata  = rsp.dep + wtd_pkg::DEPTH_W'(1);
    req.dist_wdata = alu_y;

    unique case (state_r)
      wtd_pkg::S_IDLE: begin
        if (in_acc) begin
          x_nxt      = in_first;
          y_nxt      = in_second;
          weight_nxt = in_edge;
          unique case (in_func)
            wtd_pkg::FUNC_CLEAR: cnt_nxt = wtd_pkg::CNT_W'(1);
            wtd_pkg::FUNC_ADD: begin
              if ((wtd_pkg::CNT_W'(in_first) < cnt_r) &&
                  (cnt_r < wtd_pkg::CNT_W'(wtd_pkg::MAX_NODES))) begin
                state_nxt = wtd_pkg::S_ADD_INIT;
              end
            end
            wtd_pkg::FUNC_QUERY: begin
              if ((wtd_pkg::CNT_W'(in_first) < cnt_r) &&
                  (wtd_pkg::CNT_W'(in_second) < cnt_r)) begin
                err_nxt   = wtd_pkg::ST_OK;
                state_nxt = wtd_pkg::S_Q_INIT;
              end else begin
                acc_nxt   = '0;
                err_nxt   = wtd_pkg::ST_ABSENT;
                state_nxt = wtd_pkg::S_RESULT;
              end
            end
            default: ;
          endcase
        end
      end

      // Insert: link level 0, read the parent's depth and distance
      wtd_pkg::S_ADD_INIT: begin
        req.anc_we    = 1'b1;
        req.anc_wlvl  = '0;
        req.anc_wdata = x_r;
        lvl_nxt       = wtd_pkg::LVL_W'(1);
        state_nxt     = wtd_pkg::S_ADD_SUM;
      end

      wtd_pkg::S_ADD_SUM: begin
        alu_a     = rsp.node_dist;
        alu_b     = wtd_pkg::DIST_W'(weight_r);
        req.nd_we = 1'b1;
        if (wtd_pkg::LIFT_LEVELS == 1) begin
          cnt_nxt   = cnt_r + wtd_pkg::CNT_W'(1);
          state_nxt = wtd_pkg::S_IDLE;
        end else begin
          state_nxt = wtd_pkg::S_ADD_RD;
        end
      end

      // Fetch the ancestor one level below on the current node
      wtd_pkg::S_ADD_RD: begin
        req.anc_rlvl = lvl_r - wtd_pkg::LVL_W'(1);
        state_nxt    = wtd_pkg::S_ADD_WR;
      end

      wtd_pkg::S_ADD_WR: begin
        req.anc_we = 1'b1;
        x_nxt      = rsp.anc_x;
        if (lvl_r == wtd_pkg::LAST_LVL) begin
          cnt_nxt   = cnt_r + wtd_pkg::CNT_W'(1);
          state_nxt = wtd_pkg::S_IDLE;
        end else begin
          lvl_nxt   = lvl_r + wtd_pkg::LVL_W'(1);
          state_nxt = wtd_pkg::S_ADD_RD;
        end
      end

      // Query: read both endpoints
      wtd_pkg::S_Q_INIT: begin
        state_nxt = wtd_pkg::S_Q_RDB;
      end

      wtd_pkg::S_Q_RDB: begin
        depa_nxt     = rsp.dep;
        acc_nxt      = rsp.node_dist;
        req.nd_raddr = y_r;
        state_nxt    = wtd_pkg::S_Q_ORDER;
      end

      // Sum both distances, put the deeper node in x
      wtd_pkg::S_Q_ORDER: begin
        acc_nxt = alu_y;
        if (depa_r < rsp.dep) begin
          x_nxt     = y_r;
          y_nxt     = x_r;
          diff_full = rsp.dep - depa_r;
        end else begin
          diff_full = depa_r - rsp.dep;
        end
        diff_nxt  = wtd_pkg::LIFT_LEVELS'(diff_full);
        lvl_nxt   = wtd_pkg::LAST_LVL;
        state_nxt = wtd_pkg::S_Q_LIFT;
      end

      // Lift x by the depth difference, top level first
      wtd_pkg::S_Q_LIFT: begin
        if (diff_r[lvl_r]) begin
          state_nxt = wtd_pkg::S_Q_LIFT_WR;
        end else if (lvl_r == '0) begin
          state_nxt = wtd_pkg::S_Q_MEET;
        end else begin
          lvl_nxt = lvl_r - wtd_pkg::LVL_W'(1);
        end
      end

      wtd_pkg::S_Q_LIFT_WR: begin
        x_nxt = rsp.anc_x;
        if (lvl_r == '0) begin
          state_nxt = wtd_pkg::S_Q_MEET;
        end else begin
          lvl_nxt   = lvl_r - wtd_pkg::LVL_W'(1);
          state_nxt = wtd_pkg::S_Q_LIFT;
        end
      end

      wtd_pkg::S_Q_MEET: begin
        if (x_r == y_r) begin
          state_nxt = wtd_pkg::S_Q_LCA_RD;
        end else begin
          lvl_nxt   = wtd_pkg::LAST_LVL;
          state_nxt = wtd_pkg::S_Q_JRD;
        end
      end

      // Jump both nodes while their ancestors differ
      wtd_pkg::S_Q_JRD: begin
        state_nxt = wtd_pkg::S_Q_JCMP;
      end

      wtd_pkg::S_Q_JCMP: begin
        if (rsp.anc_x != rsp.anc_y) begin
          x_nxt = rsp.anc_x;
          y_nxt = rsp.anc_y;
        end
        if (lvl_r == '0) begin
          state_nxt = wtd_pkg::S_Q_PAR;
        end else begin
          lvl_nxt   = lvl_r - wtd_pkg::LVL_W'(1);
          state_nxt = wtd_pkg::S_Q_JRD;
        end
      end

      // Common ancestor is the parent of x
      wtd_pkg::S_Q_PAR: begin
        req.anc_rlvl = '0;
        state_nxt    = wtd_pkg::S_Q_PAR_WR;
      end

      wtd_pkg::S_Q_PAR_WR: begin
        x_nxt     = rsp.anc_x;
        state_nxt = wtd_pkg::S_Q_LCA_RD;
      end

      wtd_pkg::S_Q_LCA_RD: begin
        state_nxt = wtd_pkg::S_Q_LCA_SUB;
      end

      // Subtract twice the ancestor's distance
      wtd_pkg::S_Q_LCA_SUB: begin
        alu_op    = wtd_pkg::ALU_SUB;
        alu_b     = {rsp.node_dist[wtd_pkg::DIST_W-2:0], 1'b0};
        acc_nxt   = alu_y;
        state_nxt = wtd_pkg::S_RESULT;
      end

      // Hand the answer to the output register once it is free
      wtd_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_len_nxt    = acc_r;
          out_status_nxt = err_r;
          state_nxt      = wtd_pkg::S_IDLE;
        end
      end

      default: state_nxt = wtd_pkg::S_IDLE;
    endcase
  end

endmodule

// File: design/weighted_tree_distance_lca.sv
// ----------------------------------------------------------------------------
// weighted_tree_distance_lca
// Weighted rooted tree with path-length queries by binary lifting.
// ----------------------------------------------------------------------------
// Usage: a clear transaction leaves only the root, node 0.
// An add links level 0 to the parent, then does one ancestor-table read and
// one write per further lifting level; an add with an absent parent or into a
// full table changes nothing. A query reads both endpoints, lifts the deeper
// node by the depth difference, top level first, then jumps both nodes level
// by level and forms the length. The walk goes over the single ancestor table,
// one level per read. A query naming an absent node answers with status 1 and
// length 0. The input is not ready while a transaction is in work; a finished
// answer waits in an output register.
module weighted_tree_distance_lca (
  input  logic       clk,
  input  logic       rst_n,
  wtd_in_if.sink     in_ch,
  wtd_out_if.source  out_ch
);

  wtd_pkg::tbl_req_t tbl_req;
  wtd_pkg::tbl_rsp_t tbl_rsp;

  wtd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_func    (in_ch.func),
    .in_first   (in_ch.first_node),
    .in_second  (in_ch.second_node),
    .in_edge    (in_ch.edge_length),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_len    (out_ch.path_length),
    .out_status (out_ch.status),
    .req        (tbl_req),
    .rsp        (tbl_rsp)
  );

  wtd_tables u_tables (
    .clk (clk),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

endmodule

// File: design/wtd_checker.sv
// ----------------------------------------------------------------------------
// wtd_checker
// Port-level checks for the weighted tree distance block.
// ----------------------------------------------------------------------------
`include "weighted_tree_distance_lca_defines.svh"

module wtd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [wtd_pkg::FUNC_W-1:0]  in_func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wtd_pkg::DIST_W-1:0]  out_len,
  input logic                        out_status
);

  // A stalled answer holds
  `WTD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_len) && $stable(out_status), "stalled result changed")

  // An accepted query keeps the block busy
  `WTD_ASSERT_NXT(a_query_busy, in_valid && in_ready && (in_func == wtd_pkg::FUNC_QUERY), !in_ready, "ready after query accept")

  // An absent-node answer carries zero length
  `WTD_ASSERT_IMP(a_err_zero, out_valid && (out_status == wtd_pkg::ST_ABSENT), out_len == '0, "error result with nonzero length")

  // No answer right after reset
  `WTD_ASSERT_RST(a_rst_idle, !rst_n, !out_valid, "result valid after reset")

endmodule

bind weighted_tree_distance_lca wtd_checker u_wtd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_len    (out_ch.path_length),
  .out_status (out_ch.status)
);

// File: tb/tb_weighted_tree_distance_lca.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_tree_distance_lca
// Self-checking bench for the weighted tree distance block. A queue of tree
// commands (clear, add, query, unused code) feeds a clocked driver. A monitor
// tracks its own copy of the tree tables on every input transaction and
// checks each answer, field by field, against the oldest predicted one.
// The command mix covers small random trees, one tree filled to capacity,
// absent parents and endpoints, and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_weighted_tree_distance_lca;
  import wtd_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = FUNC_W'(3);
  localparam logic [EDGE_W-1:0] EDGE_MAX    = '1;
  localparam int HOLD_AT        = 60;    // input count that starts the long stall
  localparam int HOLD_LEN       = 400;
  localparam int STALL_LIMIT    = 3000;  // cycles with no transaction at all
  localparam int SETTLE_CYCLES  = 100;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic [EDGE_W-1:0] edge_length;
    bit                drain_first;
  } tree_cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] path_length;
    logic              status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  wtd_in_if  in_ch ();
  wtd_out_if out_ch ();

  weighted_tree_distance_lca DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Stimulus and expectations
  tree_cmd_t cmd_plan[$];
  answer_t   due_answers[$];
  int        plan_count;
  int        n_cmds;
  int        items_in;
  int        results_due;
  int        errors = 0;
  int        cyc;
  int        quiet_cycles;
  logic      calm;

  // Shadow tree tables
  logic [NODE_W-1:0]  lift_tbl [MAX_NODES][LIFT_LEVELS];
  logic [DEPTH_W-1:0] tree_depth [MAX_NODES];
  logic [DIST_W-1:0]  root_dist [MAX_NODES];
  int                 node_total;

  // No random idling inside the calm window
  assign calm = (cyc % 9000) >= 6500;

  function automatic void log_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void plant_root();
    for (int j = 0; j < LIFT_LEVELS; j++) lift_tbl[0][j] = '0;
    tree_depth[0] = '0;
    root_dist[0]  = '0;
    node_total    = 1;
  endfunction

  // Lift the deeper node by the depth gap, then jump both from the top level
  function automatic logic [NODE_W-1:0] common_ancestor(logic [NODE_W-1:0] a,
                                                        logic [NODE_W-1:0] b);
    logic [NODE_W-1:0]  hi;
    logic [NODE_W-1:0]  lo;
    logic [DEPTH_W-1:0] gap;
    hi = a;
    lo = b;
    if (tree_depth[a] < tree_depth[b]) begin
      hi = b;
      lo = a;
    end
    gap = tree_depth[hi] - tree_depth[lo];
    for (int j = LIFT_LEVELS - 1; j >= 0; j--) begin
      if (gap[j]) hi = lift_tbl[hi][j];
    end
    if (hi == lo) return hi;
    for (int j = LIFT_LEVELS - 1; j >= 0; j--) begin
      if (lift_tbl[hi][j] != lift_tbl[lo][j]) begin
        hi = lift_tbl[hi][j];
        lo = lift_tbl[lo][j];
      end
    end
    return lift_tbl[hi][0];
  endfunction

  // Update the shadow tree for one command; queue the answer of a query
  function automatic void tree_step(logic [FUNC_W-1:0] func, logic [NODE_W-1:0] a,
                                    logic [NODE_W-1:0] b, logic [EDGE_W-1:0] w);
    logic [NODE_W-1:0] nn;
    logic [NODE_W-1:0] meet;
    answer_t           ans;
    case (func)
      FUNC_CLEAR: plant_root();
      FUNC_ADD: begin
        if (a < node_total && node_total < MAX_NODES) begin
          nn = NODE_W'(node_total);
          tree_depth[nn]  = tree_depth[a] + 1'b1;
          root_dist[nn]   = root_dist[a] + DIST_W'(w);
          lift_tbl[nn][0] = a;
          for (int j = 1; j < LIFT_LEVELS; j++)
            lift_tbl[nn][j] = lift_tbl[lift_tbl[nn][j-1]][j-1];
          node_total++;
        end
      end
      FUNC_QUERY: begin
        if (a >= node_total || b >= node_total) begin
          ans.path_length = '0;
          ans.status      = ST_ABSENT;
        end else begin
          meet = common_ancestor(a, b);
          ans.path_length = root_dist[a] + root_dist[b] - (root_dist[meet] << 1);
          ans.status      = ST_OK;
        end
        due_answers.insert(due_answers.size(), ans);
      end
      default: ;
    endcase
  endfunction

  // Stimulus planning; plan_count follows the node count the block will have
  function automatic void queue_cmd(logic [FUNC_W-1:0] func, logic [NODE_W-1:0] a,
                                    logic [NODE_W-1:0] b, logic [EDGE_W-1:0] w,
                                    bit force_drain);
    tree_cmd_t c;
    c.func        = func;
    c.first_node  = a;
    c.second_node = b;
    c.edge_length = w;
    c.drain_first = force_drain || ($urandom_range(99) < 2);
    cmd_plan.insert(cmd_plan.size(), c);
    if (func == FUNC_CLEAR) plan_count = 1;
    else if (func == FUNC_ADD && a < plan_count && plan_count < MAX_NODES) plan_count++;
  endfunction

  function automatic logic [EDGE_W-1:0] pick_length();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return EDGE_MAX;
    return EDGE_W'($urandom);
  endfunction

  function automatic void plan_add(int chain_pct, int bad_pct);
    int r;
    int parent;
    r = $urandom_range(99);
    if (r < chain_pct) parent = plan_count - 1;
    else if (r < chain_pct + 10) parent = 0;
    else parent = $urandom_range(plan_count - 1);
    if ($urandom_range(99) < bad_pct && plan_count < MAX_NODES)
      parent = $urandom_range(MAX_NODES - 1, plan_count);
    queue_cmd(FUNC_ADD, NODE_W'(parent), NODE_W'($urandom), pick_length(), 1'b0);
  endfunction

  function automatic void plan_query(int absent_pct);
    int a;
    int b;
    int bad;
    a = $urandom_range(plan_count - 1);
    b = ($urandom_range(19) == 0) ? a : $urandom_range(plan_count - 1);
    if ($urandom_range(99) < absent_pct && plan_count < MAX_NODES) begin
      bad = $urandom_range(MAX_NODES - 1, plan_count);
      if ($urandom_range(1)) a = bad;
      else b = bad;
    end
    queue_cmd(FUNC_QUERY, NODE_W'(a), NODE_W'(b), EDGE_W'($urandom), 1'b0);
  endfunction

  function automatic void plan_phase(int n, int chain_pct);
    int r;
    queue_cmd(FUNC_CLEAR, NODE_W'($urandom), NODE_W'($urandom), EDGE_W'($urandom), 1'b1);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45) plan_add(chain_pct, 0);
      else if (r < 78) plan_query(0);
      else if (r < 85) plan_add(chain_pct, 100);
      else if (r < 91) plan_query(100);
      else if (r < 96)
        queue_cmd(FUNC_UNUSED, NODE_W'($urandom), NODE_W'($urandom), EDGE_W'($urandom), 1'b0);
      else
        queue_cmd(FUNC_CLEAR, NODE_W'($urandom), NODE_W'($urandom), EDGE_W'($urandom), 1'b0);
    end
  endfunction

  // Driver: hold each command until accepted; pause for drain when flagged
  always @(posedge clk) begin : drive
    bit        fired;
    bit        go;
    tree_cmd_t c;
    fired = in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || fired) begin
      go = cmd_plan.size() != 0 && (calm || $urandom_range(99) >= 8);
      if (go && cmd_plan[0].drain_first) go = !fired && results_due == 0;
      if (go) begin
        c = cmd_plan.pop_front();
        in_ch.func        <= c.func;
        in_ch.first_node  <= c.first_node;
        in_ch.second_node <= c.second_node;
        in_ch.edge_length <= c.edge_length;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin : receive
    int  hold_left;
    bit  hold_done;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && items_in >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Monitor: check answers first, then advance the shadow tree
  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      plant_root();
      due_answers.delete();
      items_in    <= 0;
      results_due <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_answers.size() == 0) begin
          log_error($sformatf("unexpected result length=%0d status=%0b",
                              out_ch.path_length, out_ch.status));
        end else begin
          want = due_answers.pop_front();
          if (out_ch.path_length !== want.path_length)
            log_error($sformatf("path_length exp=%0d act=%0d",
                                want.path_length, out_ch.path_length));
          if (out_ch.status !== want.status)
            log_error($sformatf("status exp=%0b act=%0b", want.status, out_ch.status));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        tree_step(in_ch.func, in_ch.first_node, in_ch.second_node, in_ch.edge_length);
        items_in <= items_in + 1;
      end
      results_due <= due_answers.size();
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      cyc          <= 0;
      quiet_cycles <= 0;
    end else begin
      cyc <= cyc + 1;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    plan_count = 1;

    // Directed: root-only tree, absent nodes, extreme lengths, ignored adds
    queue_cmd(FUNC_CLEAR, '0, '0, '0, 1'b1);
    queue_cmd(FUNC_QUERY, '0, '0, '0, 1'b0);
    queue_cmd(FUNC_QUERY, '0, NODE_W'(1), EDGE_MAX, 1'b0);
    queue_cmd(FUNC_QUERY, '1, '1, '0, 1'b0);
    queue_cmd(FUNC_ADD, '0, '1, EDGE_MAX, 1'b0);
    queue_cmd(FUNC_ADD, NODE_W'(1), '0, '0, 1'b0);
    queue_cmd(FUNC_ADD, NODE_W'(2), '0, EDGE_MAX, 1'b0);
    queue_cmd(FUNC_ADD, NODE_W'(5), '0, EDGE_W'($urandom), 1'b0);
    queue_cmd(FUNC_ADD, '1, '1, EDGE_MAX, 1'b0);
    queue_cmd(FUNC_ADD, '0, '0, EDGE_W'(1), 1'b0);
    queue_cmd(FUNC_QUERY, NODE_W'(3), NODE_W'(4), '0, 1'b0);
    queue_cmd(FUNC_QUERY, NODE_W'(3), NODE_W'(2), '0, 1'b0);
    queue_cmd(FUNC_QUERY, NODE_W'(2), NODE_W'(3), '0, 1'b0);
    queue_cmd(FUNC_QUERY, NODE_W'(1), NODE_W'(1), '0, 1'b0);
    queue_cmd(FUNC_QUERY, NODE_W'(4), NODE_W'(5), '0, 1'b0);
    queue_cmd(FUNC_UNUSED, '1, '1, EDGE_MAX, 1'b0);
    queue_cmd(FUNC_QUERY, NODE_W'(3), '0, '0, 1'b0);
    queue_cmd(FUNC_CLEAR, '1, '1, EDGE_MAX, 1'b0);
    queue_cmd(FUNC_QUERY, NODE_W'(3), '0, '0, 1'b0);
    queue_cmd(FUNC_ADD, '0, '0, EDGE_MAX, 1'b0);
    queue_cmd(FUNC_QUERY, NODE_W'(1), '0, '0, 1'b0);

    // Random: small trees of varied shape
    repeat (8) plan_phase($urandom_range(40, 64), $urandom_range(0, 80));

    // Random: one deep tree filled to capacity, then adds into the full table
    queue_cmd(FUNC_CLEAR, NODE_W'($urandom), NODE_W'($urandom), EDGE_W'($urandom), 1'b1);
    while (plan_count < MAX_NODES) begin
      if ($urandom_range(99) < 12) plan_query(5);
      else plan_add(60, 2);
    end
    repeat (6) plan_add(30, 0);
    queue_cmd(FUNC_QUERY, '1, '0, '0, 1'b0);
    queue_cmd(FUNC_QUERY, '1, '1, '0, 1'b0);
    repeat (40) plan_query(0);
    n_cmds = cmd_plan.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every command to be taken and every answer to arrive
    while (items_in != n_cmds || results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_answers.size() != 0)
      log_error($sformatf("%0d answers never arrived", due_answers.size()));

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
